// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pad responder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CPR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define CPR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and constants shared by the pad responder modules.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam logic [7:0] CMD_PROBE  = 8'h00;
	localparam logic [7:0] CMD_POLL   = 8'h40;
	localparam logic [7:0] CMD_ORIGIN = 8'h41;

	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_CENTER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_BUTTONS = 2'd2;

	localparam logic [23:0] DEVICE_ID_RST      = 24'h090003;
	localparam logic [7:0]  ORIGIN_CENTER_RST  = 8'd127;
	localparam logic [15:0] ORIGIN_BUTTONS_RST = 16'h0080;

	localparam int JOB_BYTES = 10;
	localparam logic [3:0] CNT_PROBE  = 4'd3;
	localparam logic [3:0] CNT_ORIGIN = 4'd10;
	localparam logic [3:0] CNT_REPORT = 4'd8;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [63:0] report_state;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] tx_word;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic                   resync;
		logic [3:0]             count;
		logic [JOB_BYTES*8-1:0] bytes;
	} job_t;

endpackage

// File: rtl/cpr_front.sv
// ----------------------------------------------------------------------------
// cpr_front
// Takes command bytes, tracks the poll sequence and queues response jobs.
// ----------------------------------------------------------------------------
module cpr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  cpr_pkg::cmd_t                     cmd,
	input  logic                              cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cpr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              job_full,
	output logic                              job_push,
	output cpr_pkg::job_t                     job
);
	import cpr_pkg::*;

	typedef enum logic [1:0] {
		PH_CMD   = 2'd0,
		PH_POLL1 = 2'd1,
		PH_POLL2 = 2'd2
	} phase_t;

	phase_t      phase_q;
	logic [63:0] report_q;
	logic [23:0] device_id_q;
	logic [7:0]  center_q;
	logic [15:0] buttons_q;
	logic        accept;

	assign full   = job_full;
	assign accept = push && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= DEVICE_ID_RST;
			center_q    <= ORIGIN_CENTER_RST;
			buttons_q   <= ORIGIN_BUTTONS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ID:      device_id_q <= cfg_data;
				REG_ORIGIN_CENTER:  center_q    <= cfg_data[7:0];
				REG_ORIGIN_BUTTONS: buttons_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
		end else if (accept) begin
			case (phase_q)
				PH_POLL1: phase_q <= PH_POLL2;
				PH_POLL2: phase_q <= PH_CMD;
				default:  phase_q <= (cmd.rx_byte == CMD_POLL) ? PH_POLL1 : PH_CMD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_POLL1) begin
			report_q <= cmd.report_state;
		end
	end

	always_comb begin
		job        = '0;
		job_push   = 1'b0;
		case (phase_q)
			PH_POLL1: job_push = 1'b0;
			PH_POLL2: begin
				job_push  = accept;
				job.count = CNT_REPORT;
				job.bytes = {report_q, 16'h0000};
			end
			default: begin
				job_push = accept && (cmd.rx_byte != CMD_POLL);
				case (cmd.rx_byte)
					CMD_PROBE: begin
						job.count = CNT_PROBE;
						job.bytes = {device_id_q, 56'h0};
					end
					CMD_ORIGIN: begin
						job.count = CNT_ORIGIN;
						job.bytes = {buttons_q, center_q, center_q, center_q, center_q,
							32'h0};
					end
					default: job.resync = 1'b1;
				endcase
			end
		endcase
	end

endmodule

// File: rtl/cpr_job_fifo.sv
// ----------------------------------------------------------------------------
// cpr_job_fifo
// Two-entry queue of response jobs between the front and back halves.
// ----------------------------------------------------------------------------
module cpr_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cpr_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output logic          head_valid,
	output cpr_pkg::job_t head
);
	import cpr_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign do_wr      = wr_en && !full;
	assign do_rd      = rd_en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: rtl/cpr_back.sv
// ----------------------------------------------------------------------------
// cpr_back
// Queued jobs become line words in an output register, one per cycle unless held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  cpr_pkg::job_t head,
	output logic          job_pop,
	output logic          empty,
	input  logic          pop,
	output cpr_pkg::rsp_t rsp
);
	import cpr_pkg::*;

	logic [2:0] word_q;
	logic       out_valid_q;
	rsp_t       out_q;
	logic       advance;
	logic       is_last;
	logic [3:0] idx0;
	logic [3:0] idx1;
	rsp_t       next_rsp;

	function automatic logic [7:0] pick_byte(input logic [JOB_BYTES*8-1:0] bytes,
		input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		for (int k = 0; k < JOB_BYTES; k++) begin
			if (idx == 4'(k)) r = bytes[JOB_BYTES*8-1-8*k -: 8];
		end
		return r;
	endfunction

	function automatic logic [15:0] encode_half(input logic [JOB_BYTES*8-1:0] bytes,
		input logic [3:0] count, input logic [3:0] idx);
		logic [15:0] r;
		logic [7:0]  b;
		r = 16'h0000;
		b = pick_byte(bytes, idx);
		if (idx < count) begin
			for (int s = 0; s < 8; s++) begin
				r[2*s+1] = 1'b1;
				r[2*s]   = b[7-s];
			end
		end else if (idx == count) begin
			r = 16'h0003;
		end
		return r;
	endfunction

	assign advance = !out_valid_q || pop;
	assign job_pop = advance && head_valid && is_last;
	assign empty   = !out_valid_q;
	assign rsp     = out_q;
	assign idx0    = {word_q, 1'b0};
	assign idx1    = {word_q, 1'b1};
	assign is_last = head.resync || (word_q == head.count[3:1]);

	always_comb begin
		next_rsp.kind = head.resync;
		next_rsp.last = is_last;
		if (head.resync) begin
			next_rsp.tx_word = 32'h0;
		end else begin
			next_rsp.tx_word = {encode_half(head.bytes, head.count, idx1),
				encode_half(head.bytes, head.count, idx0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				word_q <= is_last ? 3'd0 : word_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_q <= next_rsp;
		end
	end

	`CPR_ASSERT(a_idle_word_zero, clk, arst_n, !head_valid |-> word_q == 3'd0, "word index left nonzero without a job")
	`CPR_NEVER(a_word_range, clk, arst_n, word_q > 3'd5, "word index past the longest response")
	`CPR_ASSERT(a_resync_last, clk, arst_n, (out_valid_q && out_q.kind) |-> out_q.last, "resync result not marked last")

endmodule

// File: rtl/console_pad_poll_responder_top.sv
// ----------------------------------------------------------------------------
// console_pad_poll_responder_top
// Pad side responder: command bytes in, line words of 2-bit symbols out.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   push / full        cmd   (rx_byte, report_state)
//  result    empty / pop        rsp   (kind, tx_word, last)
//  config    cfg_we             cfg_index, cfg_data
//
// A command byte is taken every cycle while the two-entry job queue has room.
// The back half emits one line word per cycle unless a result waits: 2 for probe,
// 6 for origin, 5 for a poll report, 1 for resync.
// A response's first word passes through the job queue, then the output register.
// Reset restores the register defaults and empties both queues; no clearing pass.
// A stalled result holds the back half, and full rises once two jobs wait.
// ----------------------------------------------------------------------------
module console_pad_poll_responder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  cpr_pkg::cmd_t                 cmd,
	output logic                          empty,
	input  logic                          pop,
	output cpr_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpr_pkg::CFG_W-1:0]     cfg_data
);
	import cpr_pkg::*;

	logic job_full;
	logic job_push;
	job_t job;
	logic job_pop;
	logic head_valid;
	job_t head;

	cpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (job)
	);

	cpr_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (job_push),
		.wr_job     (job),
		.full       (job_full),
		.rd_en      (job_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	cpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.job_pop    (job_pop),
		.empty      (empty),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
